@@ rtl/core/tgarle_pkg.sv @@
package tgarle_pkg;

  localparam int unsigned BppWidth    = 3;
  localparam int unsigned PixWidth    = 25;
  localparam int unsigned IndexWidth  = 24;
  localparam int unsigned CfgWidth    = 25;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [BppWidth-1:0] BppReset    = 3'd3;
  localparam logic [BppWidth-1:0] BppMin      = 3'd1;
  localparam logic [BppWidth-1:0] BppMax      = 3'd4;
  localparam logic [PixWidth-1:0] PixelsReset = 25'd1;
  localparam logic [PixWidth-1:0] PixelsMin   = 25'd1;
  localparam logic [PixWidth-1:0] PixelsMax   = 25'h1000000;
  localparam logic [7:0]          RunBase     = 8'd127;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_BPP    = 1'b0,
    CFG_PIXELS = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RAW    = 2'd1,
    PH_RUN    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [31:0]           pixel_value;
    logic [7:0]            run_length;
    logic [IndexWidth-1:0] start_index;
    logic                  image_done;
    logic                  overrun;
  } result_t;

endpackage

@@ rtl/core/tgarle_if.sv @@
interface tgarle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tgarle_run_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  run_length;
  logic [23:0] start_index;
  logic        image_done;
  logic        overrun;

  modport source (output valid, output pixel_value, output run_length, output start_index,
                  output image_done, output overrun, input ready);
  modport sink (input valid, input pixel_value, input run_length, input start_index,
                input image_done, input overrun, output ready);
endinterface

@@ rtl/core/tgarle_skid.sv @@
module tgarle_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tgarle_pkg::result_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tgarle_pkg::result_t out_data_o
);

  logic                main_valid_q, main_valid_d;
  logic                skid_valid_q, skid_valid_d;
  tgarle_pkg::result_t main_q, main_d;
  tgarle_pkg::result_t skid_q, skid_d;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_valid_q && !out_ready_i) begin
      if (in_valid_i && !skid_valid_q) begin
        skid_valid_d = 1'b1;
        skid_d       = in_data_i;
      end
    end else if (skid_valid_q) begin
      main_valid_d = 1'b1;
      main_d       = skid_q;
      skid_valid_d = 1'b0;
    end else begin
      main_valid_d = in_valid_i;
      main_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("Skid entry held without a waiting result.");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_valid_q && !out_ready_i |=> main_valid_q && $stable(main_q))
    else $error("Stalled result changed.");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_ready_i |=> !skid_valid_q)
    else $error("Skid entry not moved forward after a transfer.");

endmodule

@@ rtl/core/tga_rle_pixel_decoder_unit.sv @@
// Channel   Role    Handshake      Payload
// byte_in   sink    valid/ready    data_byte[7:0]
// run_out   source  valid/ready    pixel_value, run_length, start_index, image_done, overrun
// cfg       write   cfg_we_i       cfg_index_i, cfg_data_i[24:0]
//
// One byte is taken in every cycle while the output stage has room; its decode completes in
// that cycle and a result, when the byte finishes a pixel, is registered in the output stage.
// A two-entry output stage keeps input flowing under a stalled result until a second result
// is waiting; input is then taken again in the cycle after the first of them is transferred.
// Reset is asynchronous and active low; it restores the register defaults and awaits a header.
module tga_rle_pixel_decoder_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  tgarle_byte_if.sink                           byte_in,
  tgarle_run_if.source                          run_out,
  input  logic                                  cfg_we_i,
  input  logic [tgarle_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [tgarle_pkg::CfgWidth-1:0]       cfg_data_i
);

  logic [tgarle_pkg::BppWidth-1:0] bpp_q;
  logic [tgarle_pkg::PixWidth-1:0] pixels_q;

  tgarle_pkg::phase_e              phase_q, phase_d;
  logic [7:0]                      packet_left_q, packet_left_d;
  logic [1:0]                      byte_slot_q, byte_slot_d;
  logic [31:0]                     gather_q, gather_d;
  logic [tgarle_pkg::PixWidth-1:0] pixels_done_q, pixels_done_d;

  logic                            accept;
  logic                            in_ready;
  logic                            res_valid;
  tgarle_pkg::result_t             res;
  tgarle_pkg::result_t             out_data;

  logic [tgarle_pkg::BppWidth-1:0] bpp_eff;
  logic [tgarle_pkg::PixWidth-1:0] limit;
  logic [tgarle_pkg::PixWidth-1:0] remaining;
  logic [7:0]                      want;
  logic [tgarle_pkg::PixWidth-1:0] want_w;
  logic                            want_big;
  logic [tgarle_pkg::PixWidth-1:0] len;
  logic                            last;
  logic                            clipped;
  logic [31:0]                     gather_new;
  logic                            pixel_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= tgarle_pkg::BppReset;
      pixels_q <= tgarle_pkg::PixelsReset;
    end else if (cfg_we_i) begin
      unique case (tgarle_pkg::cfg_index_e'(cfg_index_i))
        tgarle_pkg::CFG_BPP: begin
          bpp_q <= cfg_data_i[tgarle_pkg::BppWidth-1:0];
        end
        tgarle_pkg::CFG_PIXELS: begin
          pixels_q <= cfg_data_i[tgarle_pkg::PixWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (bpp_q < tgarle_pkg::BppMin) begin
      bpp_eff = tgarle_pkg::BppMin;
    end else if (bpp_q > tgarle_pkg::BppMax) begin
      bpp_eff = tgarle_pkg::BppMax;
    end else begin
      bpp_eff = bpp_q;
    end
    if (pixels_q < tgarle_pkg::PixelsMin) begin
      limit = tgarle_pkg::PixelsMin;
    end else if (pixels_q > tgarle_pkg::PixelsMax) begin
      limit = tgarle_pkg::PixelsMax;
    end else begin
      limit = pixels_q;
    end
  end

  assign accept     = byte_in.valid && in_ready;
  assign gather_new = gather_q | ({24'd0, byte_in.data_byte} << {byte_slot_q, 3'b000});
  assign pixel_end  = ({1'b0, byte_slot_q} + 3'd1) >= bpp_eff;

  always_comb begin
    remaining = (pixels_done_q < limit) ? (limit - pixels_done_q) : 25'd1;
    want      = (phase_q == tgarle_pkg::PH_RAW) ? 8'd1 : packet_left_q;
    if (want == 8'd0) begin
      want = 8'd1;
    end
    want_w   = {17'd0, want};
    want_big = want_w > remaining;
    len      = want_big ? remaining : want_w;
    last     = len == remaining;
    clipped  = want_big ||
               ((phase_q == tgarle_pkg::PH_RAW) && last && (packet_left_q > 8'd1));
  end

  always_comb begin
    phase_d       = phase_q;
    packet_left_d = packet_left_q;
    byte_slot_d   = byte_slot_q;
    gather_d      = gather_q;
    pixels_done_d = pixels_done_q;
    if (accept) begin
      unique case (phase_q)
        tgarle_pkg::PH_RAW, tgarle_pkg::PH_RUN: begin
          if (!pixel_end) begin
            gather_d    = gather_new;
            byte_slot_d = byte_slot_q + 2'd1;
          end else begin
            gather_d    = '0;
            byte_slot_d = '0;
            if (last) begin
              pixels_done_d = '0;
              phase_d       = tgarle_pkg::PH_HEADER;
              packet_left_d = '0;
            end else begin
              pixels_done_d = pixels_done_q + len;
              if ((phase_q == tgarle_pkg::PH_RAW) && (packet_left_q > 8'd1)) begin
                packet_left_d = packet_left_q - 8'd1;
              end else begin
                phase_d       = tgarle_pkg::PH_HEADER;
                packet_left_d = '0;
              end
            end
          end
        end
        default: begin
          if (!byte_in.data_byte[7]) begin
            phase_d       = tgarle_pkg::PH_RAW;
            packet_left_d = byte_in.data_byte + 8'd1;
          end else begin
            phase_d       = tgarle_pkg::PH_RUN;
            packet_left_d = byte_in.data_byte - tgarle_pkg::RunBase;
          end
          byte_slot_d = '0;
          gather_d    = '0;
        end
      endcase
    end
  end

  always_comb begin
    res.pixel_value = gather_new;
    res.run_length  = len[7:0];
    res.start_index = pixels_done_q[tgarle_pkg::IndexWidth-1:0];
    res.image_done  = last;
    res.overrun     = clipped;
    res_valid       = accept && pixel_end &&
                      ((phase_q == tgarle_pkg::PH_RAW) || (phase_q == tgarle_pkg::PH_RUN));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= tgarle_pkg::PH_HEADER;
      packet_left_q <= '0;
      byte_slot_q   <= '0;
      gather_q      <= '0;
      pixels_done_q <= '0;
    end else begin
      phase_q       <= phase_d;
      packet_left_q <= packet_left_d;
      byte_slot_q   <= byte_slot_d;
      gather_q      <= gather_d;
      pixels_done_q <= pixels_done_d;
    end
  end

  tgarle_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (res),
    .out_valid_o (run_out.valid),
    .out_ready_i (run_out.ready),
    .out_data_o  (out_data)
  );

  assign byte_in.ready       = in_ready;
  assign run_out.pixel_value = out_data.pixel_value;
  assign run_out.run_length  = out_data.run_length;
  assign run_out.start_index = out_data.start_index;
  assign run_out.image_done  = out_data.image_done;
  assign run_out.overrun     = out_data.overrun;

  a_header_slot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tgarle_pkg::PH_HEADER |-> byte_slot_q == 2'd0 && gather_q == 32'd0)
    else $error("Pixel gather left over while awaiting a header.");

  a_done_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.image_done |=> pixels_done_q == '0 && phase_q == tgarle_pkg::PH_HEADER)
    else $error("Image end did not restart the pixel count.");

  a_overrun_ends_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.overrun |-> res.image_done)
    else $error("Clipped packet without image end.");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res.run_length != 8'd0)
    else $error("Result with zero run length.");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TotalBytes   = 1850;
  localparam int unsigned CalmBytes    = 200;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned SettleCycles = 3;
  localparam int unsigned WatchLimit   = 4000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned PlanRows     = 33;

  typedef struct packed {
    bit                              is_reg;
    tgarle_pkg::cfg_index_e          reg_idx;
    logic [tgarle_pkg::CfgWidth-1:0] value;
    bit                              typed;
    tgarle_pkg::result_t             want;
  } plan_row_t;

  localparam tgarle_pkg::result_t NoRun = '0;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  tgarle_pkg::cfg_index_e          cfg_index;
  logic [tgarle_pkg::CfgWidth-1:0] cfg_data;

  tgarle_byte_if byte_ch ();
  tgarle_run_if  run_ch ();

  tga_rle_pixel_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_in     (byte_ch),
    .run_out     (run_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Decoder state and register copies used for prediction.
  logic [tgarle_pkg::BppWidth-1:0] cfg_bpp;
  logic [tgarle_pkg::PixWidth-1:0] cfg_pixels;
  tgarle_pkg::phase_e              pd_phase;
  logic [7:0]                      pd_left;
  logic [1:0]                      pd_slot;
  logic [31:0]                     pd_gather;
  logic [tgarle_pkg::PixWidth-1:0] pd_done;

  tgarle_pkg::result_t runs_due[$];

  int unsigned bytes_sent;
  int unsigned reg_writes;
  int unsigned runs_seen;
  int unsigned images_seen;
  int unsigned clipped_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          hold_request;

  // The directed stream: reset registers first, then the extremes and out-of-range settings.
  plan_row_t plan [PlanRows] = '{
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h00,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h11,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h22,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h33,      1'b1,
      '{32'h0033_2211, 8'd1, 24'd0, 1'b1, 1'b0}},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'hFF,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'hFF,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'hFF,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'hFF,      1'b1,
      '{32'h00FF_FFFF, 8'd1, 24'd0, 1'b1, 1'b1}},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h05,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h00,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h00,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h00,      1'b1,
      '{32'h0000_0000, 8'd1, 24'd0, 1'b1, 1'b1}},
    '{1'b1, tgarle_pkg::CFG_BPP,    25'd4,       1'b0, NoRun},
    '{1'b1, tgarle_pkg::CFG_PIXELS, 25'd300,     1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'hFF,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h00,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'hFF,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h80,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h7F,      1'b1,
      '{32'h7F80_FF00, 8'd128, 24'd0, 1'b0, 1'b0}},
    '{1'b1, tgarle_pkg::CFG_BPP,    25'd1,       1'b0, NoRun},
    '{1'b1, tgarle_pkg::CFG_PIXELS, 25'd0,       1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h81,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'hAB,      1'b1,
      '{32'h0000_00AB, 8'd1, 24'd128, 1'b1, 1'b1}},
    '{1'b1, tgarle_pkg::CFG_BPP,    25'd0,       1'b0, NoRun},
    '{1'b1, tgarle_pkg::CFG_PIXELS, 25'h1FFFFFF, 1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h00,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h5A,      1'b0, NoRun},
    '{1'b1, tgarle_pkg::CFG_BPP,    25'd7,       1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h7F,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h01,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h02,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h03,      1'b0, NoRun},
    '{1'b0, tgarle_pkg::CFG_BPP,    25'h04,      1'b0, NoRun}
  };

  function automatic void decode_byte(input logic [7:0] b, output bit got,
                                      output tgarle_pkg::result_t r);
    int unsigned bpp;
    int unsigned lim;
    int unsigned remaining;
    int unsigned want;
    int unsigned len;
    bit          clipped;
    got = 1'b0;
    r = '0;
    if (pd_phase != tgarle_pkg::PH_RAW && pd_phase != tgarle_pkg::PH_RUN) begin
      if (b < 8'd128) begin
        pd_phase = tgarle_pkg::PH_RAW;
        pd_left = b + 8'd1;
      end else begin
        pd_phase = tgarle_pkg::PH_RUN;
        pd_left = b - tgarle_pkg::RunBase;
      end
      pd_slot = '0;
      pd_gather = '0;
      return;
    end
    pd_gather = pd_gather | (32'(b) << {pd_slot, 3'b000});
    bpp = (cfg_bpp == '0) ? 1 :
          (cfg_bpp > tgarle_pkg::BppMax) ? tgarle_pkg::BppMax : cfg_bpp;
    if (pd_slot + 1 < bpp) begin
      pd_slot = pd_slot + 2'd1;
      return;
    end
    lim = (cfg_pixels == '0) ? 1 :
          (cfg_pixels > tgarle_pkg::PixelsMax) ? tgarle_pkg::PixelsMax : cfg_pixels;
    remaining = (pd_done < lim) ? lim - pd_done : 1;
    want = (pd_phase == tgarle_pkg::PH_RAW) ? 1 : pd_left;
    if (want == 0) want = 1;
    clipped = (want > remaining);
    len = clipped ? remaining : want;
    if (pd_phase == tgarle_pkg::PH_RAW && len == remaining && pd_left > 8'd1) clipped = 1'b1;
    got = 1'b1;
    r.pixel_value = pd_gather;
    r.run_length  = len[7:0];
    r.start_index = pd_done[tgarle_pkg::IndexWidth-1:0];
    r.image_done  = (len == remaining);
    r.overrun     = clipped;
    pd_slot = '0;
    pd_gather = '0;
    if (len == remaining) begin
      pd_done = '0;
      pd_phase = tgarle_pkg::PH_HEADER;
      pd_left = '0;
    end else begin
      pd_done = pd_done + tgarle_pkg::PixWidth'(len);
      if (pd_phase == tgarle_pkg::PH_RAW && pd_left > 8'd1) begin
        pd_left = pd_left - 8'd1;
      end else begin
        pd_phase = tgarle_pkg::PH_HEADER;
        pd_left = '0;
      end
    end
  endfunction

  // Headers lean towards short packets so that images end often; pixel bytes hit the extremes.
  function automatic logic [7:0] next_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pd_phase == tgarle_pkg::PH_HEADER) begin
      if (pick < 45) return 8'($urandom_range(0, 7));
      if (pick < 55) return 8'($urandom_range(0, 127));
      if (pick < 90) return 8'($urandom_range(128, 143));
      return 8'($urandom_range(128, 255));
    end
    if (pick < 10) return 8'h00;
    if (pick < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [tgarle_pkg::CfgWidth-1:0] pick_pixels();
    case ($urandom_range(0, 9))
      0: return tgarle_pkg::PixelsMin;
      1: return '0;
      2: return tgarle_pkg::PixelsMax;
      3: return tgarle_pkg::PixelsMax +
                tgarle_pkg::CfgWidth'($urandom_range(1, 24'hFF_FFFF));
      4, 5, 6: return tgarle_pkg::CfgWidth'($urandom_range(2, 40));
      7, 8: return tgarle_pkg::CfgWidth'($urandom_range(41, 600));
      default: return tgarle_pkg::CfgWidth'($urandom_range(601, 70000));
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 6;
      default: return 30;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input tgarle_pkg::result_t hand);
    bit                  got;
    tgarle_pkg::result_t r;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    bytes_sent++;
    decode_byte(b, got, r);
    if (got) runs_due.push_back(typed ? hand : r);
  endtask

  // A header byte gives no result, so the stream is also left to settle before any register write.
  task automatic drain_runs();
    byte_ch.valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input tgarle_pkg::cfg_index_e idx,
                           input logic [tgarle_pkg::CfgWidth-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == tgarle_pkg::CFG_BPP) cfg_bpp = value[tgarle_pkg::BppWidth-1:0];
    else cfg_pixels = value;
    reg_writes++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    run_ch.ready = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        run_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        run_ch.ready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        run_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        run_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_runs
    tgarle_pkg::result_t seen;
    tgarle_pkg::result_t due;
    if (run_ch.valid && run_ch.ready) begin
      seen = '{run_ch.pixel_value, run_ch.run_length, run_ch.start_index,
               run_ch.image_done, run_ch.overrun};
      runs_seen++;
      if (seen.image_done) images_seen++;
      if (seen.overrun) clipped_seen++;
      if (runs_due.size() == 0) begin
        if (mismatches < MaxReports)
          $display("Unexpected pixel group: value %h length %0d index %0d done %b overrun %b",
                   seen.pixel_value, seen.run_length, seen.start_index, seen.image_done,
                   seen.overrun);
        mismatches++;
      end else begin
        due = runs_due.pop_front();
        if (seen.pixel_value !== due.pixel_value || seen.run_length !== due.run_length ||
            seen.start_index !== due.start_index || seen.image_done !== due.image_done ||
            seen.overrun !== due.overrun) begin
          if (mismatches < MaxReports)
            $display("Pixel group %0d: expected %h/%0d/%0d/%b/%b, got %h/%0d/%0d/%b/%b",
                     runs_seen, due.pixel_value, due.run_length, due.start_index,
                     due.image_done, due.overrun, seen.pixel_value, seen.run_length,
                     seen.start_index, seen.image_done, seen.overrun);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (run_ch.valid && run_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WatchLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned phase_len;
    int unsigned phase_no;
    bit          calm;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tgarle_pkg::CFG_BPP;
    cfg_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    cfg_bpp = tgarle_pkg::BppReset;
    cfg_pixels = tgarle_pkg::PixelsReset;
    pd_phase = tgarle_pkg::PH_HEADER;
    pd_left = '0;
    pd_slot = '0;
    pd_gather = '0;
    pd_done = '0;
    bytes_sent = 0;
    reg_writes = 0;
    runs_seen = 0;
    images_seen = 0;
    clipped_seen = 0;
    mismatches = 0;
    quiet_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PlanRows; i++) begin
      if (plan[i].is_reg) begin
        drain_runs();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_byte(plan[i].value[7:0], plan[i].typed, plan[i].want);
      end
    end

    // Each phase starts only once every pixel group of the one before has been transferred.
    phase_no = 0;
    while (bytes_sent < TotalBytes) begin
      drain_runs();
      calm = (bytes_sent >= TotalBytes - CalmBytes);
      if ($urandom_range(0, 9) < 6) begin
        write_reg(tgarle_pkg::CFG_BPP, tgarle_pkg::CfgWidth'($urandom_range(0, 7)));
      end
      if ($urandom_range(0, 9) < 6) write_reg(tgarle_pkg::CFG_PIXELS, pick_pixels());
      if (calm) begin
        gap_pct = 0;
        stall_pct = 0;
        phase_len = TotalBytes - bytes_sent;
      end else begin
        gap_pct = pick_pct();
        stall_pct = pick_pct();
        phase_len = $urandom_range(15, 90);
      end
      if (phase_no == 1) begin
        write_reg(tgarle_pkg::CFG_BPP, tgarle_pkg::CfgWidth'(1));
        gap_pct = 0;
        hold_request = 1'b1;
        phase_len = 80;
      end
      repeat (phase_len) send_byte(next_byte(), 1'b0, NoRun);
      phase_no++;
    end

    drain_runs();
    if (runs_due.size() != 0) mismatches += runs_due.size();
    $display("Decoded %0d stream bytes across %0d register writes; %0d pixel groups checked.",
             bytes_sent, reg_writes, runs_seen);
    $display("%0d images completed, %0d pixel groups clipped at the image end.",
             images_seen, clipped_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tgarle_pkg.sv
rtl/core/tgarle_if.sv
rtl/core/tgarle_skid.sv
rtl/core/tga_rle_pixel_decoder_unit.sv
sim/tb_top.sv
